// File: hw/rtl/fsslm_pkg.sv
// shared types and constants for the flex sensor servo level mapper
// no dependencies; used by fsslm_div, flex_sensor_servo_level_mapper, its checker and testbench
package fsslm_pkg;

   localparam int REG_W     = 12;  // width of calibration and threshold registers
   localparam int ANGLE_W   = 8;
   localparam int LAMP_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 20;  // 12-bit difference times 180

   localparam logic [ANGLE_W-1:0] ANGLE_FULL = 8'd180;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_STRAIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BENT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_MID  = 3'd3;

   // register reset values
   localparam logic [REG_W-1:0] CAL_STRAIGHT_RST   = 12'd3054;
   localparam logic [REG_W-1:0] CAL_BENT_RST       = 12'd2766;
   localparam logic [REG_W-1:0] THRESHOLD_HIGH_RST = 12'd2910;
   localparam logic [REG_W-1:0] THRESHOLD_MID_RST  = 12'd2795;

   // lamp codes
   localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd0;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd1;
   localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd2;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_AVG_DIV,
      ST_MAP_MUL,
      ST_MAP_START,
      ST_MAP_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: hw/rtl/fsslm_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on fsslm_pkg for the status struct
module fsslm_div #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVIDEND_W-1:0]      dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output logic [DIVIDEND_W-1:0]      quotient,
   output fsslm_pkg::div_status_type  status
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   always_comb begin
      trial   = {rem_ff, dq_ff[DIVIDEND_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      diff    = trial - {1'b0, dvs_ff};
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dq_in   = {dq_ff[DIVIDEND_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = dq_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

// File: hw/rtl/flex_sensor_servo_level_mapper.sv
// top level of the flex sensor servo level mapper: sample accumulation,
// sequencer around one shared serial divider, output register
// depends on fsslm_pkg and fsslm_div
//
// Sums raw ADC samples and, after every SAMPLES_PER_READING samples, emits one
// beat with the truncated mean, a bend angle of 0..180 mapped linearly between
// cal_straight (angle 0) and cal_bent (angle 180) after clamping to that
// range, the servo position 180 - angle, a flag set on the first beat or when
// the angle changed, and a red/yellow/green lamp code from the two thresholds
// on the unclamped mean. Equal calibration points give angle 0. Samples are
// taken one per cycle while accumulating; after the sample that completes a
// reading, req_tready stays low while the shared divider, which yields one
// quotient bit per cycle, runs twice: once for the mean, once for the angle
// map. With equal calibration points the second divide is skipped. A result
// still waiting on rsp_tready when the next reading is ready keeps req_tready
// low until the output register frees up; accumulation itself is never held
// by the result side. Register writes are always taken; index values above
// three are ignored.
module flex_sensor_servo_level_mapper #(
   parameter int SAMPLES_PER_READING = 20,
   parameter int ADC_BITS            = 12
) (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] average, [19:12] angle,
                                    // [27:20] servo_position, [28] servo_update,
                                    // [30:29] lamp_code
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int REG_W  = fsslm_pkg::REG_W;
   localparam int ANG_W  = fsslm_pkg::ANGLE_W;
   localparam int PROD_W = fsslm_pkg::PROD_W;
   // samples are masked to ADC_BITS within the 12-bit field
   localparam int MASK_W = (ADC_BITS < REG_W) ? ADC_BITS : REG_W;
   localparam logic [REG_W-1:0] SMP_MASK =
      (ADC_BITS >= REG_W) ? {REG_W{1'b1}} : REG_W'((1 << ADC_BITS) - 1);
   localparam int SUM_W  = MASK_W + $clog2(SAMPLES_PER_READING);
   localparam int CNT_W  = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
   localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

   // configuration registers
   logic [REG_W-1:0] cal_straight_ff, cal_straight_in;
   logic [REG_W-1:0] cal_bent_ff, cal_bent_in;
   logic [REG_W-1:0] thr_high_ff, thr_high_in;
   logic [REG_W-1:0] thr_mid_ff, thr_mid_in;

   // sequencer and accumulation state
   fsslm_pkg::state_type state_ff, state_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ANG_W-1:0]  prev_angle_ff, prev_angle_in;
   logic              angle_seen_ff, angle_seen_in;

   // working registers
   logic [REG_W-1:0]  avg_ff, avg_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [REG_W-1:0]  den_ff, den_in;
   logic [ANG_W-1:0]  angle_ff, angle_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   // shared divider
   logic                      div_start;
   logic [DIV_W-1:0]          div_dividend;
   logic [REG_W-1:0]          div_divisor;
   logic [DIV_W-1:0]          div_quotient;
   fsslm_pkg::div_status_type div_stat;

   logic [REG_W-1:0]  smp;
   logic [SUM_W-1:0]  sum_plus;
   logic              req_beat;
   logic              last_sample;
   logic              ascending;
   logic [REG_W-1:0]  lo, hi, x_clamp, diff;
   logic              update;
   logic [1:0]        lamp;
   logic [ANG_W-1:0]  servo_pos;

   fsslm_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (REG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cal_straight_in = cal_straight_ff;
      cal_bent_in     = cal_bent_ff;
      thr_high_in     = thr_high_ff;
      thr_mid_in      = thr_mid_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fsslm_pkg::CSR_CAL_STRAIGHT:   cal_straight_in = csr_data;
            fsslm_pkg::CSR_CAL_BENT:       cal_bent_in     = csr_data;
            fsslm_pkg::CSR_THRESHOLD_HIGH: thr_high_in     = csr_data;
            fsslm_pkg::CSR_THRESHOLD_MID:  thr_mid_in      = csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // sample path
   assign smp         = req_tdata[11:0] & SMP_MASK;
   assign sum_plus    = sum_ff + SUM_W'(smp);
   assign req_tready  = (state_ff == fsslm_pkg::ST_ACC);
   assign req_beat    = req_tvalid && req_tready;
   assign last_sample = (count_ff == CNT_W'(SAMPLES_PER_READING - 1));

   // clamp and map setup, taken from the stored mean
   always_comb begin
      ascending = (cal_straight_ff <= cal_bent_ff);
      lo        = ascending ? cal_straight_ff : cal_bent_ff;
      hi        = ascending ? cal_bent_ff : cal_straight_ff;
      if (avg_ff < lo)
         x_clamp = lo;
      else if (avg_ff > hi)
         x_clamp = hi;
      else
         x_clamp = avg_ff;
      // magnitudes: both signs flip together when the points are reversed
      diff = ascending ? (x_clamp - cal_straight_ff) : (cal_straight_ff - x_clamp);
   end

   // result fields
   always_comb begin
      update    = !angle_seen_ff || (angle_ff != prev_angle_ff);
      servo_pos = fsslm_pkg::ANGLE_FULL - angle_ff;
      if (avg_ff >= thr_high_ff)
         lamp = fsslm_pkg::LAMP_GREEN;
      else if (avg_ff >= thr_mid_ff)
         lamp = fsslm_pkg::LAMP_YELLOW;
      else
         lamp = fsslm_pkg::LAMP_RED;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      prev_angle_in = prev_angle_ff;
      angle_seen_in = angle_seen_ff;
      avg_in        = avg_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      angle_in      = angle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_dividend  = DIV_W'(sum_plus);
      div_divisor   = REG_W'(SAMPLES_PER_READING);

      unique case (state_ff)
         fsslm_pkg::ST_ACC: begin
            if (req_beat) begin
               if (last_sample) begin
                  // block complete: mean = sum / samples on the divider
                  sum_in    = '0;
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = fsslm_pkg::ST_AVG_DIV;
               end else begin
                  sum_in   = sum_plus;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         fsslm_pkg::ST_AVG_DIV: begin
            if (div_stat.done) begin
               avg_in   = div_quotient[REG_W-1:0];
               state_in = fsslm_pkg::ST_MAP_MUL;
            end
         end
         fsslm_pkg::ST_MAP_MUL: begin
            prod_in  = PROD_W'(diff) * PROD_W'(fsslm_pkg::ANGLE_FULL);
            den_in   = ascending ? (cal_bent_ff - cal_straight_ff)
                                 : (cal_straight_ff - cal_bent_ff);
            state_in = fsslm_pkg::ST_MAP_START;
         end
         fsslm_pkg::ST_MAP_START: begin
            if (den_ff == '0) begin
               // equal calibration points
               angle_in = '0;
               state_in = fsslm_pkg::ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(prod_ff);
               div_divisor  = den_ff;
               state_in     = fsslm_pkg::ST_MAP_DIV;
            end
         end
         fsslm_pkg::ST_MAP_DIV: begin
            if (div_stat.done) begin
               angle_in = div_quotient[ANG_W-1:0];
               state_in = fsslm_pkg::ST_EMIT;
            end
         end
         fsslm_pkg::ST_EMIT: begin
            // load the output register once it is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, lamp, update, servo_pos, angle_ff, avg_ff};
               if (update) begin
                  prev_angle_in = angle_ff;
                  angle_seen_in = 1'b1;
               end
               state_in = fsslm_pkg::ST_ACC;
            end
         end
         default: state_in = fsslm_pkg::ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_straight_ff <= fsslm_pkg::CAL_STRAIGHT_RST;
         cal_bent_ff     <= fsslm_pkg::CAL_BENT_RST;
         thr_high_ff     <= fsslm_pkg::THRESHOLD_HIGH_RST;
         thr_mid_ff      <= fsslm_pkg::THRESHOLD_MID_RST;
         state_ff        <= fsslm_pkg::ST_ACC;
         sum_ff          <= '0;
         count_ff        <= '0;
         prev_angle_ff   <= '0;
         angle_seen_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cal_straight_ff <= cal_straight_in;
         cal_bent_ff     <= cal_bent_in;
         thr_high_ff     <= thr_high_in;
         thr_mid_ff      <= thr_mid_in;
         state_ff        <= state_in;
         sum_ff          <= sum_in;
         count_ff        <= count_in;
         prev_angle_ff   <= prev_angle_in;
         angle_seen_ff   <= angle_seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      angle_ff    <= angle_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == fsslm_pkg::ST_AVG_DIV ||
                         state_ff == fsslm_pkg::ST_MAP_DIV))
      else $error("divider busy outside a divide state");

   // a waiting result is never overwritten by the next one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsslm_pkg::ST_EMIT && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == fsslm_pkg::ST_EMIT))
      else $error("result emitted while output register still full");

   // angle and servo position always add up to full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[19:12] <= fsslm_pkg::ANGLE_FULL &&
                        rsp_data_ff[19:12] + rsp_data_ff[27:20] ==
                        fsslm_pkg::ANGLE_FULL))
      else $error("angle out of range or servo position mismatch");

   // the last emitted angle is kept as the change reference
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsslm_pkg::ST_EMIT && (!rsp_valid_ff || rsp_tready))
      |=> (angle_seen_ff && prev_angle_ff == rsp_data_ff[19:12]))
      else $error("change reference not updated on emit");

endmodule

// File: verif/flex_sensor_servo_level_mapper_checker.sv
// beat monitor and result predictor for the flex sensor servo level mapper
// depends on fsslm_pkg; watches the sample, result and register channels

module flex_sensor_servo_level_mapper_checker #(
   parameter int SAMPLES_PER_READING = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data,
   output int          mismatch_count,
   output int          readings_pending,
   output int          readings_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam int REG_W        = fsslm_pkg::REG_W;
   localparam int ANGLE_W      = fsslm_pkg::ANGLE_W;
   localparam int LAMP_W       = fsslm_pkg::LAMP_W;

   typedef struct packed {
      logic [REG_W-1:0]   average;
      logic [ANGLE_W-1:0] angle;
      logic [ANGLE_W-1:0] servo_position;
      logic               servo_update;
      logic [LAMP_W-1:0]  lamp_code;
   } reading_type;

   // register copies
   logic [REG_W-1:0]   cal_straight_q;
   logic [REG_W-1:0]   cal_bent_q;
   logic [REG_W-1:0]   thr_high_q;
   logic [REG_W-1:0]   thr_mid_q;

   // accumulation and angle history
   logic [17:0]        sample_sum_q;
   int                 sample_count_q;
   logic [ANGLE_W-1:0] last_angle_q;
   logic               angle_seen_q;

   reading_type        expected_readings[$];
   int                 errors;
   int                 checked;

   // clamp to the calibration span, then scale so straight -> 0 and bent -> 180
   function automatic logic [ANGLE_W-1:0] bend_angle(input logic [REG_W-1:0] mean);
      longint s, b, lo, hi, x, q, full;
      s    = cal_straight_q;
      b    = cal_bent_q;
      full = fsslm_pkg::ANGLE_FULL;
      if (s == b)
         return '0;
      lo = (s < b) ? s : b;
      hi = (s < b) ? b : s;
      x  = mean;
      if (x < lo)
         x = lo;
      if (x > hi)
         x = hi;
      q = ((x - s) * full) / (b - s);
      if (q < 0)
         q = 0;
      if (q > full)
         q = full;
      return q[ANGLE_W-1:0];
   endfunction

   task automatic take_sample(input logic [REG_W-1:0] smp);
      reading_type        r;
      logic [17:0]        mean_full;
      logic [ANGLE_W-1:0] ang;
      sample_sum_q   = sample_sum_q + smp;
      sample_count_q = sample_count_q + 1;
      if (sample_count_q < SAMPLES_PER_READING)
         return;
      mean_full      = 18'(sample_sum_q / SAMPLES_PER_READING);
      sample_sum_q   = '0;
      sample_count_q = 0;
      ang            = bend_angle(mean_full[REG_W-1:0]);
      r.average        = mean_full[REG_W-1:0];
      r.angle          = ang;
      r.servo_position = fsslm_pkg::ANGLE_FULL - ang;
      r.servo_update   = !angle_seen_q || (ang != last_angle_q);
      if (r.servo_update) begin
         last_angle_q = ang;
         angle_seen_q = 1'b1;
      end
      if (mean_full >= thr_high_q)
         r.lamp_code = fsslm_pkg::LAMP_GREEN;
      else if (mean_full >= thr_mid_q)
         r.lamp_code = fsslm_pkg::LAMP_YELLOW;
      else
         r.lamp_code = fsslm_pkg::LAMP_RED;
      expected_readings.push_back(r);
   endtask

   task automatic check_reading(input logic [31:0] beat);
      reading_type want, got;
      got.average        = beat[11:0];
      got.angle          = beat[19:12];
      got.servo_position = beat[27:20];
      got.servo_update   = beat[28];
      got.lamp_code      = beat[30:29];
      if (expected_readings.size() == 0) begin
         errors = errors + 1;
         if (errors <= REPORT_LIMIT)
            $display("%0t: result beat with no reading pending: %h", $realtime, beat);
         return;
      end
      want    = expected_readings.pop_front();
      checked = checked + 1;
      if (got.average != want.average || got.angle != want.angle ||
          got.servo_position != want.servo_position ||
          got.servo_update != want.servo_update || got.lamp_code != want.lamp_code) begin
         errors = errors + 1;
         if (errors <= REPORT_LIMIT)
            $display("%0t: reading %0d expected avg=%0d angle=%0d servo=%0d upd=%0b lamp=%0d,",
                     $realtime, checked, want.average, want.angle, want.servo_position,
                     want.servo_update, want.lamp_code,
                     " got avg=%0d angle=%0d servo=%0d upd=%0b lamp=%0d",
                     got.average, got.angle, got.servo_position, got.servo_update,
                     got.lamp_code);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cal_straight_q = fsslm_pkg::CAL_STRAIGHT_RST;
         cal_bent_q     = fsslm_pkg::CAL_BENT_RST;
         thr_high_q     = fsslm_pkg::THRESHOLD_HIGH_RST;
         thr_mid_q      = fsslm_pkg::THRESHOLD_MID_RST;
         sample_sum_q   = '0;
         sample_count_q = 0;
         last_angle_q   = '0;
         angle_seen_q   = 1'b0;
         errors         = 0;
         checked        = 0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fsslm_pkg::CSR_CAL_STRAIGHT:   cal_straight_q = csr_data;
               fsslm_pkg::CSR_CAL_BENT:       cal_bent_q     = csr_data;
               fsslm_pkg::CSR_THRESHOLD_HIGH: thr_high_q     = csr_data;
               fsslm_pkg::CSR_THRESHOLD_MID:  thr_mid_q      = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            take_sample(req_tdata[REG_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            check_reading(rsp_tdata);
      end
      mismatch_count   <= errors;
      readings_pending <= expected_readings.size();
      readings_checked <= checked;
   end

endmodule

// File: verif/flex_sensor_servo_level_mapper_tb.sv
// top of the flex sensor servo level mapper testbench: clock, reset, stimulus, verdict
// depends on fsslm_pkg, flex_sensor_servo_level_mapper and its checker module

module flex_sensor_servo_level_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES_PER_READING = 20;
   localparam int NUM_PHASES          = 12;    // register settings after the directed block
   localparam int ITEMS_PER_PHASE     = 150;
   localparam int DRAIN_CYCLES        = 64;    // covers the divide window
   localparam int STALL_LIMIT         = 2000;  // cycles with no beat on any channel
   localparam int SMP_W               = fsslm_pkg::REG_W;
   localparam int IDX_W               = fsslm_pkg::CSR_IDX_W;
   localparam int FIRST_UNUSED_INDEX  = 4;
   localparam int LAST_INDEX          = (1 << IDX_W) - 1;
   localparam int SAMPLE_MAX          = (1 << SMP_W) - 1;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [11:0] sample
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [11:0] average, [19:12] angle, [27:20] servo_position,
                              // [28] servo_update, [30:29] lamp_code
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [11:0] csr_data;

   int mismatch_count;
   int readings_pending;
   int readings_checked;

   // stimulus bookkeeping
   int samples_sent = 0;
   int block_pos    = 0;      // position of the next sample inside its reading
   int level        = 0;      // center value of the current reading
   int spread       = 0;      // noise half-width around the level
   int quiet_cycles = 0;
   bit req_calm     = 1'b0;   // sender never idles while set
   bit rsp_calm     = 1'b0;   // receiver never stalls while set

   // register values currently programmed, used only to aim the stimulus
   int cfg_straight = fsslm_pkg::CAL_STRAIGHT_RST;
   int cfg_bent     = fsslm_pkg::CAL_BENT_RST;
   int cfg_high     = fsslm_pkg::THRESHOLD_HIGH_RST;
   int cfg_mid      = fsslm_pkg::THRESHOLD_MID_RST;

   flex_sensor_servo_level_mapper #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING),
      .ADC_BITS           (SMP_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   flex_sensor_servo_level_mapper_checker #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING)
   ) reading_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .readings_pending(readings_pending),
      .readings_checked(readings_checked)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random stall before each beat, none while calm
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int clip_sample(input int x);
      if (x < 0)
         return 0;
      if (x > SAMPLE_MAX)
         return SAMPLE_MAX;
      return x;
   endfunction

   // one sample beat; valid stays high across back-to-back beats and is only
   // dropped when a gap is drawn
   task automatic send_sample(input logic [SMP_W-1:0] value);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, value};
      do @(posedge clock); while (!req_tready);
      samples_sent = samples_sent + 1;
      block_pos    = (block_pos + 1) % SAMPLES_PER_READING;
   endtask

   // csr_valid is left high so that writes can run back to back
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // stop sending, wait for every pending reading, then let the divider settle
   task automatic drain_readings();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (readings_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // program all four registers, sometimes followed by a write to an unused index
   task automatic set_config(input int s, input int b, input int h, input int m);
      write_reg(fsslm_pkg::CSR_CAL_STRAIGHT, SMP_W'(s));
      write_reg(fsslm_pkg::CSR_CAL_BENT, SMP_W'(b));
      write_reg(fsslm_pkg::CSR_THRESHOLD_HIGH, SMP_W'(h));
      write_reg(fsslm_pkg::CSR_THRESHOLD_MID, SMP_W'(m));
      if ($urandom_range(0, 1) == 1)
         write_reg(IDX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)),
                   SMP_W'($urandom_range(0, SAMPLE_MAX)));
      csr_valid <= 1'b0;
      cfg_straight = s;
      cfg_bent     = b;
      cfg_high     = h;
      cfg_mid      = m;
   endtask

   // a new level is drawn at the start of each reading; the samples of that
   // reading scatter around it so the mean lands where the mode aims
   task automatic pick_sample(output logic [SMP_W-1:0] value);
      int lo_cal, hi_cal, raw;
      if (block_pos == 0) begin
         lo_cal = (cfg_straight < cfg_bent) ? cfg_straight : cfg_bent;
         hi_cal = (cfg_straight < cfg_bent) ? cfg_bent : cfg_straight;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // inside or just outside the calibration span
               level  = $urandom_range(clip_sample(lo_cal - 120), clip_sample(hi_cal + 120));
               spread = $urandom_range(0, 30);
            end
            5: begin
               // right at a lamp threshold
               raw    = ($urandom_range(0, 1) == 1) ? cfg_high : cfg_mid;
               level  = clip_sample(raw + $urandom_range(0, 4) - 2);
               spread = 0;
            end
            6: begin
               // same level again with no spread, so the angle repeats when the last reading had none
               spread = 0;
            end
            7: begin
               level  = $urandom_range(0, SAMPLE_MAX);
               spread = $urandom_range(0, 200);
            end
            8: begin
               // pure noise over the whole range
               level  = (SAMPLE_MAX + 1) / 2;
               spread = (SAMPLE_MAX + 1) / 2;
            end
            default: begin
               level  = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
               spread = 0;
            end
         endcase
      end
      raw   = $urandom_range(0, 2 * spread);
      raw   = raw + level - spread;
      value = SMP_W'(clip_sample(raw));
   endtask

   initial begin
      logic [SMP_W-1:0] smp;
      int s, b, h, m;
      int phase, i;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed reading at reset settings: sample extremes and alternating bit patterns,
      // first result always flags an update
      for (i = 0; i < SAMPLES_PER_READING; i++) begin
         case (i % 4)
            0: smp = SMP_W'(SAMPLE_MAX);
            1: smp = '0;
            2: smp = 12'hAAA;
            default: smp = 12'h555;
         endcase
         send_sample(smp);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // sender holds off here until every reading is back (idle before csr writes)
         drain_readings();
         req_calm = (phase % 4 == 1);
         rsp_calm = (phase % 4 == 2);
         case (phase)
            0: begin s = 0;          b = SAMPLE_MAX; h = SAMPLE_MAX; m = 0;          end
            // reversed calibration, thresholds out of order
            1: begin s = SAMPLE_MAX; b = 0;          h = 0;          m = SAMPLE_MAX; end
            // equal calibration points, angle pinned at zero
            2: begin s = 2000;       b = 2000;       h = 2100;       m = 1900;       end
            3: begin s = 2766;       b = 3054;       h = 2910;       m = 2795;       end
            // one-count span, steep map
            4: begin s = 1000;       b = 1001;       h = 1001;       m = 1000;       end
            5: begin s = 0;          b = 0;          h = 0;          m = 0;          end
            6: begin s = SAMPLE_MAX; b = SAMPLE_MAX; h = SAMPLE_MAX; m = SAMPLE_MAX; end
            7: begin
               s = fsslm_pkg::CAL_STRAIGHT_RST;   b = fsslm_pkg::CAL_BENT_RST;
               h = fsslm_pkg::THRESHOLD_HIGH_RST; m = fsslm_pkg::THRESHOLD_MID_RST;
            end
            default: begin
               s = $urandom_range(0, SAMPLE_MAX);
               b = clip_sample(s + $urandom_range(0, 1200) - 600);
               h = $urandom_range(0, SAMPLE_MAX);
               m = $urandom_range(0, SAMPLE_MAX);
            end
         endcase
         set_config(s, b, h, m);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // one extra full pause in the middle of a phase
            if (phase == 9 && i == ITEMS_PER_PHASE / 2)
               drain_readings();
            pick_sample(smp);
            send_sample(smp);
         end
      end

      // all samples are in; wait out the last reading and the divider tail
      req_tvalid <= 1'b0;
      do @(posedge clock); while (readings_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent over %0d register settings, %0d readings compared",
               samples_sent, NUM_PHASES + 1, readings_checked);
      $display("%0d mismatching or unexpected beats, %0d readings never returned",
               mismatch_count, readings_pending);
      if (mismatch_count == 0 && readings_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
